>>> rtl/core/hre_pkg.sv
// types, character codes and helper functions for the hex record encoder
package hre_pkg;

  // command codes of an input word
  typedef enum logic [1:0] {
    CMD_HEADER = 2'd0,
    CMD_DATA   = 2'd1,
    CMD_END    = 2'd2
  } cmd_t;

  // one ASCII character of record text
  typedef logic [6:0] char_t;

  // most characters one input word can cause
  localparam int unsigned MaxChars = 12;

  // longest S19 data record that still fits the count byte
  localparam logic [7:0] S19_MAX_LEN = 8'd252;

  localparam char_t CHAR_COLON   = 7'h3A;
  localparam char_t CHAR_S       = 7'h53;
  localparam char_t CHAR_ONE     = 7'h31;
  localparam char_t CHAR_ZERO    = 7'h30;
  localparam char_t CHAR_NEWLINE = 7'h0A;

  // end-of-file records, newline included
  localparam char_t IHX_END [MaxChars] = '{
    7'h3A, 7'h30, 7'h30, 7'h30, 7'h30, 7'h30,
    7'h30, 7'h30, 7'h31, 7'h46, 7'h46, 7'h0A
  };
  localparam logic [3:0] IHX_END_LEN = 4'd12;

  localparam char_t S19_END [MaxChars] = '{
    7'h53, 7'h39, 7'h30, 7'h33, 7'h30, 7'h30,
    7'h30, 7'h30, 7'h46, 7'h43, 7'h0A, 7'h00
  };
  localparam logic [3:0] S19_END_LEN = 4'd11;

  // upper-case hex digit of one nibble
  function automatic char_t hex_char(input logic [3:0] nib);
    char_t c;
    if (nib < 4'd10) begin
      c = 7'h30 + {3'b000, nib};
    end else begin
      c = 7'h37 + {3'b000, nib};
    end
    return c;
  endfunction

endpackage

>>> rtl/core/hex_record_encoder_core.sv
// hex record encoder: load records in, Intel HEX or S19 text out, one character a word
//
//   port group  | direction | handshake           | contents
//   in_*        | input     | in_valid / in_stall   | cmd, record length, address, data byte
//   out_*       | output    | out_valid / out_stall | one character, last-of-word flag
//   cfg_*       | input     | cfg_valid / cfg_ready | output format (0 Intel HEX, 1 S19)
//
// each input word is decoded into the buffer; its characters leave at one per cycle
// unless out_stall holds them; a word has 2 to 12 characters, a dropped word none
// the character buffer between the decode and the output register sets that rate
// the next word is taken in the cycle its predecessor's last character moves out
// reset (synchronous, rst_n low) closes any open record and selects Intel HEX
// out_stall holds the output register; the buffer and then in_stall back up behind it
module hex_record_encoder_core (
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_record_length,
  input  logic [15:0] in_load_address,
  input  logic [7:0]  in_data_byte,
  // result words
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_char,
  output logic        out_last_of_item,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_output_format
);

  // registers
  logic                 fmt_r, fmt_nxt;
  logic [7:0]           sum_r, sum_nxt;
  logic [7:0]           owed_r, owed_nxt;
  logic                 gen_valid_r, gen_valid_nxt;
  logic [3:0]           gen_idx_r, gen_idx_nxt;
  logic [3:0]           gen_cnt_r, gen_cnt_nxt;
  hre_pkg::char_t       gen_chars_r [hre_pkg::MaxChars];
  hre_pkg::char_t       gen_chars_nxt [hre_pkg::MaxChars];
  logic                 out_valid_r, out_valid_nxt;
  hre_pkg::char_t       out_char_r, out_char_nxt;
  logic                 out_last_r, out_last_nxt;

  // handshake terms
  logic                 in_accept;
  logic                 out_load;
  logic                 gen_last;

  // decode terms
  hre_pkg::cmd_t        cmd;
  logic                 hdr_ok, data_ok, end_ok, emit;
  logic                 hdr_empty, data_last;
  logic [7:0]           count_byte, hdr_sum, data_sum, cs_src, cs_byte;
  hre_pkg::char_t       chars [hre_pkg::MaxChars];
  logic [3:0]           char_cnt;

  assign cmd       = hre_pkg::cmd_t'(in_cmd);
  assign out_load  = !out_valid_r || !out_stall;
  assign gen_last  = (gen_idx_r == gen_cnt_r - 4'd1);
  assign in_stall  = gen_valid_r && !(out_load && gen_last);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // acceptance checks and running sums
  always_comb begin
    count_byte = fmt_r ? (in_record_length + 8'd3) : in_record_length;
    hdr_sum    = count_byte + in_load_address[15:8] + in_load_address[7:0];
    data_sum   = sum_r + in_data_byte;
    hdr_empty  = (in_record_length == 8'd0);
    data_last  = (owed_r == 8'd1);
    hdr_ok     = (cmd == hre_pkg::CMD_HEADER) && (owed_r == 8'd0) &&
                 !(fmt_r && (in_record_length > hre_pkg::S19_MAX_LEN));
    data_ok    = (cmd == hre_pkg::CMD_DATA) && (owed_r != 8'd0);
    end_ok     = (cmd == hre_pkg::CMD_END) && (owed_r == 8'd0);
    emit       = in_accept && (hdr_ok || data_ok || end_ok);
    cs_src     = (cmd == hre_pkg::CMD_HEADER) ? hdr_sum : data_sum;
    cs_byte    = fmt_r ? ~cs_src : (8'd0 - cs_src);
  end

  // character line of the incoming word
  always_comb begin
    for (int i = 0; i < hre_pkg::MaxChars; i++) begin
      chars[i] = hre_pkg::CHAR_ZERO;
    end
    char_cnt = 4'd0;
    case (cmd)
      hre_pkg::CMD_HEADER: begin
        if (fmt_r) begin
          chars[0]  = hre_pkg::CHAR_S;
          chars[1]  = hre_pkg::CHAR_ONE;
          chars[2]  = hre_pkg::hex_char(count_byte[7:4]);
          chars[3]  = hre_pkg::hex_char(count_byte[3:0]);
          chars[4]  = hre_pkg::hex_char(in_load_address[15:12]);
          chars[5]  = hre_pkg::hex_char(in_load_address[11:8]);
          chars[6]  = hre_pkg::hex_char(in_load_address[7:4]);
          chars[7]  = hre_pkg::hex_char(in_load_address[3:0]);
          chars[8]  = hre_pkg::hex_char(cs_byte[7:4]);
          chars[9]  = hre_pkg::hex_char(cs_byte[3:0]);
          chars[10] = hre_pkg::CHAR_NEWLINE;
          char_cnt  = hdr_empty ? 4'd11 : 4'd8;
        end else begin
          chars[0]  = hre_pkg::CHAR_COLON;
          chars[1]  = hre_pkg::hex_char(count_byte[7:4]);
          chars[2]  = hre_pkg::hex_char(count_byte[3:0]);
          chars[3]  = hre_pkg::hex_char(in_load_address[15:12]);
          chars[4]  = hre_pkg::hex_char(in_load_address[11:8]);
          chars[5]  = hre_pkg::hex_char(in_load_address[7:4]);
          chars[6]  = hre_pkg::hex_char(in_load_address[3:0]);
          chars[7]  = hre_pkg::CHAR_ZERO;
          chars[8]  = hre_pkg::CHAR_ZERO;
          chars[9]  = hre_pkg::hex_char(cs_byte[7:4]);
          chars[10] = hre_pkg::hex_char(cs_byte[3:0]);
          chars[11] = hre_pkg::CHAR_NEWLINE;
          char_cnt  = hdr_empty ? 4'd12 : 4'd9;
        end
      end
      hre_pkg::CMD_DATA: begin
        chars[0] = hre_pkg::hex_char(in_data_byte[7:4]);
        chars[1] = hre_pkg::hex_char(in_data_byte[3:0]);
        chars[2] = hre_pkg::hex_char(cs_byte[7:4]);
        chars[3] = hre_pkg::hex_char(cs_byte[3:0]);
        chars[4] = hre_pkg::CHAR_NEWLINE;
        char_cnt = data_last ? 4'd5 : 4'd2;
      end
      hre_pkg::CMD_END: begin
        for (int i = 0; i < hre_pkg::MaxChars; i++) begin
          chars[i] = fmt_r ? hre_pkg::S19_END[i] : hre_pkg::IHX_END[i];
        end
        char_cnt = fmt_r ? hre_pkg::S19_END_LEN : hre_pkg::IHX_END_LEN;
      end
      default: begin
        char_cnt = 4'd0;
      end
    endcase
  end

  // record state and format register
  always_comb begin
    fmt_nxt  = fmt_r;
    sum_nxt  = sum_r;
    owed_nxt = owed_r;
    if (cfg_valid && cfg_ready) begin
      fmt_nxt = cfg_output_format;
    end
    if (in_accept && hdr_ok) begin
      sum_nxt  = hdr_sum;
      owed_nxt = in_record_length;
    end else if (in_accept && data_ok) begin
      sum_nxt  = data_sum;
      owed_nxt = owed_r - 8'd1;
    end
  end

  // character buffer: drains one character per output load, refills on emit
  always_comb begin
    gen_valid_nxt = gen_valid_r;
    gen_idx_nxt   = gen_idx_r;
    gen_cnt_nxt   = gen_cnt_r;
    gen_chars_nxt = gen_chars_r;
    if (gen_valid_r && out_load) begin
      gen_idx_nxt = gen_idx_r + 4'd1;
      if (gen_last) begin
        gen_valid_nxt = 1'b0;
      end
    end
    if (emit) begin
      gen_valid_nxt = 1'b1;
      gen_idx_nxt   = 4'd0;
      gen_cnt_nxt   = char_cnt;
      gen_chars_nxt = chars;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (out_load) begin
      out_valid_nxt = gen_valid_r;
      out_char_nxt  = gen_chars_r[gen_idx_r];
      out_last_nxt  = gen_last;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r       <= 1'b0;
      sum_r       <= 8'd0;
      owed_r      <= 8'd0;
      gen_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fmt_r       <= fmt_nxt;
      sum_r       <= sum_nxt;
      owed_r      <= owed_nxt;
      gen_valid_r <= gen_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    gen_idx_r   <= gen_idx_nxt;
    gen_cnt_r   <= gen_cnt_nxt;
    gen_chars_r <= gen_chars_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_char         = out_char_r;
  assign out_last_of_item = out_last_r;

  // an empty buffer always takes a word
  a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
    !gen_valid_r |-> !in_stall)
    else $error("input stalled with an empty character buffer");

  // a loaded line has between one and twelve characters
  a_line_len: assert property (@(posedge clk) disable iff (!rst_n)
    gen_valid_r |-> (gen_cnt_r != 4'd0) && (gen_cnt_r <= 4'd12) && (gen_idx_r < gen_cnt_r))
    else $error("character line length or index out of range");

  // a header into an open record leaves the record untouched
  a_hdr_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (cmd == hre_pkg::CMD_HEADER) && (owed_r != 8'd0)
    |=> $stable(owed_r) && $stable(sum_r))
    else $error("header changed an open record");

  // the last character of a line empties the buffer unless a new word arrives
  a_line_done: assert property (@(posedge clk) disable iff (!rst_n)
    gen_valid_r && out_load && gen_last && !emit |=> !gen_valid_r)
    else $error("buffer still valid after its last character");

  // a delivered last-of-word flag comes from the final index of the line
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    gen_valid_r && out_load |=> out_valid_r && (out_last_r == $past(gen_last)))
    else $error("last-of-word flag does not match the line end");

endmodule
